FILE: rtl/core/slrg_pkg.sv
// Shared constants for the shuffled Lehmer random generator.
package slrg_pkg;

  localparam int VALUE_W = 31;
  localparam int MULT_W  = 15;
  localparam int PROD_W  = VALUE_W + MULT_W;

  localparam logic [MULT_W-1:0]  LCG_MULT = 15'd16807;
  localparam logic [VALUE_W-1:0] LCG_MOD  = 31'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] SEED_RST = 31'd1;

  localparam int TABLE_SIZE_DEF = 32;

endpackage

FILE: rtl/core/shuffled_lehmer_random_generator_unit.sv
// Shuffled Lehmer random generator: minimal standard multiplicative core with a shuffle table.
//
// Input channel: in_valid / in_stall with in_reseed. Each accepted word asks
// for one random number; in_reseed = 1 reloads the generator from the seed
// register first. The first request after reset always seeds.
// Output channel: out_valid / out_stall with out_value (31 bits, never 0).
// Configuration: cfg_wr_en / cfg_wr_data write the seed register (reset 1);
// a seed of 0 or 2^31-1 is replaced by 1 when seeding.
// A plain draw first reads the shuffle table and steps the multiplier, then
// folds the product and swaps the table slot. A seeding draw first runs the
// warm-up steps, each a multiply state followed by a fold state (the fold
// states of the last TABLE_SIZE steps fill the table), then a plain draw.
// A new word is accepted only once the previous draw has finished; in_stall
// is high while a draw is in progress.
// The finished result sits in an output register; a new word is accepted
// while it waits, and a draw only stalls in its final cycle if the previous
// result has still not been taken.
// Reset (rst_n, synchronous, active low) clears control state and the seeded
// flag and sets the seed register to 1; table contents are only valid after seeding.
module shuffled_lehmer_random_generator_unit #(
  parameter int TABLE_SIZE = slrg_pkg::TABLE_SIZE_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_reseed,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [slrg_pkg::VALUE_W-1:0] out_value,
  input  logic                         cfg_wr_en,
  input  logic [slrg_pkg::VALUE_W-1:0] cfg_wr_data
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int CNT_W = $clog2(TABLE_SIZE + 8);
  localparam int VW    = slrg_pkg::VALUE_W;
  localparam int PW    = slrg_pkg::PROD_W;
  localparam longint SLOT_DIV = 1 + (longint'(2147483646) / TABLE_SIZE);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_SEED_MUL  = 3'd1;
  localparam logic [2:0] ST_SEED_FOLD = 3'd2;
  localparam logic [2:0] ST_DRAW_MUL  = 3'd3;
  localparam logic [2:0] ST_DRAW_FOLD = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [VW-1:0]    gen_r, gen_nxt;
  logic [VW-1:0]    held_r, held_nxt;
  logic [VW-1:0]    seed_r;
  logic             seeded_r, seeded_nxt;
  logic [PW-1:0]    prod_r;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [VW-1:0]    out_value_r, out_value_nxt;

  logic             in_acc;
  logic             out_free;
  logic [VW-1:0]    seed_fix;
  logic [VW:0]      fold_sum;
  logic [VW-1:0]    fold_val;
  logic [IDX_W-1:0] slot_calc;
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr;
  logic [VW-1:0]    ram_rdata;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  assign seed_fix = ((seed_r == '0) || (seed_r == slrg_pkg::LCG_MOD)) ?
                    slrg_pkg::SEED_RST : seed_r;

  // end-around fold for modulus 2^31-1; the sum stays below twice the modulus
  assign fold_sum = {1'b0, prod_r[VW-1:0]} + (VW+1)'(prod_r[PW-1:VW]);
  assign fold_val = (fold_sum >= {1'b0, slrg_pkg::LCG_MOD}) ?
                    VW'(fold_sum - {1'b0, slrg_pkg::LCG_MOD}) : fold_sum[VW-1:0];

  // slot = held / SLOT_DIV as a thermometer of constant thresholds
  always_comb begin
    slot_calc = '0;
    for (int k = 1; k < TABLE_SIZE; k++) begin
      if ({1'b0, held_r} >= (VW+1)'(longint'(k) * SLOT_DIV)) begin
        slot_calc = slot_calc + IDX_W'(1);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    gen_nxt       = gen_r;
    held_nxt      = held_r;
    seeded_nxt    = seeded_r;
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = slot_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!seeded_r || in_reseed) begin
            gen_nxt   = seed_fix;
            cnt_nxt   = CNT_W'(TABLE_SIZE + 7);
            state_nxt = ST_SEED_MUL;
          end else begin
            ram_re    = 1'b1;
            slot_nxt  = slot_calc;
            state_nxt = ST_DRAW_FOLD;
          end
        end
      end
      ST_SEED_MUL: begin
        state_nxt = ST_SEED_FOLD;
      end
      ST_SEED_FOLD: begin
        gen_nxt = fold_val;
        if (cnt_r < CNT_W'(TABLE_SIZE)) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_r[IDX_W-1:0];
        end
        if (cnt_r == '0) begin
          held_nxt   = fold_val;  // entry 0 gets this same word
          seeded_nxt = 1'b1;
          state_nxt  = ST_DRAW_MUL;
        end else begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = ST_SEED_MUL;
        end
      end
      ST_DRAW_MUL: begin
        ram_re    = 1'b1;
        slot_nxt  = slot_calc;
        state_nxt = ST_DRAW_FOLD;
      end
      ST_DRAW_FOLD: begin
        if (out_free) begin
          gen_nxt       = fold_val;
          held_nxt      = ram_rdata;
          ram_we        = 1'b1;
          out_valid_nxt = 1'b1;
          out_value_nxt = ram_rdata;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      gen_r       <= '0;
      held_r      <= '0;
      seed_r      <= slrg_pkg::SEED_RST;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      gen_r       <= gen_nxt;
      held_r      <= held_nxt;
      seeded_r    <= seeded_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r      <= slot_nxt;
    out_value_r <= out_value_nxt;
    // product holds while a draw waits on the output register
    if (state_r != ST_DRAW_FOLD) begin
      prod_r <= PW'(gen_r) * PW'(slrg_pkg::LCG_MULT);
    end
  end

  // read in the multiply cycle, write in the fold cycle: same-slot swap is safe
  slrg_ram #(
    .WIDTH (VW),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (fold_val),
    .rd_en   (ram_re),
    .rd_addr (slot_calc),
    .rd_data (ram_rdata)
  );

endmodule

FILE: rtl/core/slrg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module slrg_ram #(
  parameter int WIDTH = slrg_pkg::VALUE_W,
  parameter int DEPTH = slrg_pkg::TABLE_SIZE_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the shuffled Lehmer random generator unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TBL_DEPTH   = slrg_pkg::TABLE_SIZE_DEF;
  localparam int unsigned SLOT_SPAN   = 1 + 32'h7FFF_FFFE / TBL_DEPTH;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          CHUNK_WORDS = 42;

  localparam logic [slrg_pkg::VALUE_W-1:0] EDGE_SEEDS [4] = '{
    31'd0, 31'd1, 31'd2147483646, 31'h7FFF_FFFF
  };

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         in_reseed = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b1;
  logic [slrg_pkg::VALUE_W-1:0] out_value;
  logic                         cfg_wr_en = 1'b0;
  logic [slrg_pkg::VALUE_W-1:0] cfg_wr_data = '0;

  // predictor state
  logic [slrg_pkg::VALUE_W-1:0] seed_reg;
  logic [slrg_pkg::VALUE_W-1:0] lehmer_state;
  logic [slrg_pkg::VALUE_W-1:0] held_value;
  logic [slrg_pkg::VALUE_W-1:0] shuffle_slots [TBL_DEPTH];
  bit                           is_seeded;

  logic [slrg_pkg::VALUE_W-1:0] pending_values [$];
  logic [slrg_pkg::VALUE_W-1:0] want_value;

  int send_gap_pct;
  int recv_stall_pct;
  int mismatches;
  int cycle_count;
  int draws_sent;
  int reseed_draws;
  int seed_writes;

  shuffled_lehmer_random_generator_unit #(
    .TABLE_SIZE(TBL_DEPTH)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_reseed  (in_reseed),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [slrg_pkg::VALUE_W-1:0] lehmer_step(
    input logic [slrg_pkg::VALUE_W-1:0] x
  );
    logic [63:0] prod;
    prod = 64'(x) * 64'(slrg_pkg::LCG_MULT);
    return slrg_pkg::VALUE_W'(prod % 64'(slrg_pkg::LCG_MOD));
  endfunction

  // warm-up: TBL_DEPTH + 8 steps, the last TBL_DEPTH fill the table top down
  function automatic void refill_shuffle_table();
    logic [slrg_pkg::VALUE_W-1:0] x;
    x = seed_reg;
    if (x == '0 || x == slrg_pkg::LCG_MOD) x = 31'd1;
    for (int i = TBL_DEPTH + 7; i >= 0; i--) begin
      x = lehmer_step(x);
      if (i < TBL_DEPTH) shuffle_slots[i] = x;
    end
    lehmer_state = x;
    held_value   = shuffle_slots[0];
    is_seeded    = 1'b1;
  endfunction

  function automatic logic [slrg_pkg::VALUE_W-1:0] predict_draw(input bit reseed);
    int unsigned slot;
    if (!is_seeded || reseed) refill_shuffle_table();
    lehmer_state = lehmer_step(lehmer_state);
    slot = 32'(held_value) / SLOT_SPAN;
    if (slot >= TBL_DEPTH) slot = slot % TBL_DEPTH;
    held_value          = shuffle_slots[slot];
    shuffle_slots[slot] = lehmer_state;
    return held_value;
  endfunction

  // result checker and receiver stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_values.size() == 0) begin
        $error("value: no word expected, got %0d", out_value);
        mismatches++;
      end else begin
        want_value = pending_values.pop_front();
        if (out_value !== want_value) begin
          $error("value: expected %0d, got %0d", want_value, out_value);
          mismatches++;
        end
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words outstanding",
               cycle_count, pending_values.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_draw(input bit reseed);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid  <= 1'b0;
      in_reseed <= 1'($urandom_range(1));
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_reseed <= reseed;
    do @(posedge clk); while (in_stall);
    pending_values.push_back(predict_draw(reseed));
    draws_sent++;
    if (reseed) reseed_draws++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_values.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_seed(input logic [slrg_pkg::VALUE_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    seed_reg = value;
    seed_writes++;
  endtask

  // first draw after reset seeds from the reset seed even without reseed
  task automatic test_power_on_seed();
    send_draw(1'b0);
    send_draw(1'b0);
    send_draw(1'b1);
    wait_drained();
  endtask

  // a new seed only takes effect on the next reseed; 0 and 2^31-1 fall back to 1
  task automatic test_seed_extremes();
    logic [slrg_pkg::VALUE_W-1:0] seeds [6];
    seeds[0] = EDGE_SEEDS[0];
    seeds[1] = EDGE_SEEDS[1];
    seeds[2] = EDGE_SEEDS[2];
    seeds[3] = EDGE_SEEDS[3];
    seeds[4] = 31'h5555_5555;
    seeds[5] = 31'h2AAA_AAAA;
    foreach (seeds[i]) begin
      write_seed(seeds[i]);
      send_draw(1'b0);
      send_draw(1'b1);
      send_draw(1'b0);
      wait_drained();
    end
  endtask

  task automatic test_random_stream(input int gap_pct, input int stall_pct);
    logic [slrg_pkg::VALUE_W-1:0] seed_pick;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    for (int chunk = 0; chunk < 4; chunk++) begin
      if ($urandom_range(7) == 0) seed_pick = EDGE_SEEDS[$urandom_range(3)];
      else seed_pick = slrg_pkg::VALUE_W'($urandom);
      write_seed(seed_pick);
      for (int n = 0; n < CHUNK_WORDS; n++) send_draw($urandom_range(19) == 0);
      wait_drained();
    end
  endtask

  initial begin
    seed_reg     = slrg_pkg::SEED_RST;
    lehmer_state = '0;
    held_value   = '0;
    is_seeded    = 1'b0;
    send_gap_pct   = 8;
    recv_stall_pct = 61;
    mismatches   = 0;
    cycle_count  = 0;
    draws_sent   = 0;
    reseed_draws = 0;
    seed_writes  = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_power_on_seed();
    test_seed_extremes();
    test_random_stream(8, 61);
    test_random_stream(61, 8);
    test_random_stream(0, 0);

    wait_drained();
    repeat (8) @(posedge clk);
    if (pending_values.size() != 0) begin
      $error("value: %0d expected words never arrived", pending_values.size());
      mismatches++;
    end

    $display("Checked %0d draws (%0d with reseed) over %0d seed register writes,",
             draws_sent, reseed_draws, seed_writes);
    $display("under three sender/receiver back-pressure mixes; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: shuffled_lehmer_random_generator_unit.f
rtl/core/slrg_pkg.sv
rtl/core/slrg_ram.sv
rtl/core/shuffled_lehmer_random_generator_unit.sv
bench/testbench.sv
